### rtl/hhnc_pkg.sv
// Package for the HTTP header name classifier: keyword table, state type and helpers.
package hhnc_pkg;

	localparam int KW_COUNT = 22;
	localparam int KW_MAX_CHARS = 32;
	localparam int LEN_W = 6;
	localparam int CODE_W = 5;
	localparam int MAX_NAME_LEN_DEF = 32;

	typedef logic [8*KW_MAX_CHARS-1:0] kw_text_t;
	typedef logic [LEN_W-1:0] len_t;
	typedef logic [CODE_W-1:0] code_t;
	typedef logic [KW_COUNT-1:0] match_t;

	// Per-name state as held in the state memory
	typedef struct packed {
		len_t   name_len;
		match_t match;
	} name_state_t;

	localparam name_state_t STATE_RESET = '{name_len: '0, match: '1};

	// Keywords in lower case; string literals sit right-justified, so the
	// last character of each keyword is in bits [7:0]
	localparam kw_text_t KW_TEXT [KW_COUNT] = '{
		kw_text_t'("date"),
		kw_text_t'("etag"),
		kw_text_t'("vary"),
		kw_text_t'("allow"),
		kw_text_t'("server"),
		kw_text_t'("location"),
		kw_text_t'("connection"),
		kw_text_t'("set-cookie"),
		kw_text_t'("content-type"),
		kw_text_t'("accept-ranges"),
		kw_text_t'("cache-control"),
		kw_text_t'("content-range"),
		kw_text_t'("last-modified"),
		kw_text_t'("content-length"),
		kw_text_t'("content-encoding"),
		kw_text_t'("transfer-encoding"),
		kw_text_t'("access-control-allow-origin"),
		kw_text_t'("access-control-allow-methods"),
		kw_text_t'("access-control-allow-headers"),
		kw_text_t'("access-control-max-age"),
		kw_text_t'("access-control-expose-headers"),
		kw_text_t'("access-control-allow-credentials")
	};

	localparam len_t KW_LEN [KW_COUNT] = '{
		6'd4, 6'd4, 6'd4, 6'd5, 6'd6, 6'd8, 6'd10, 6'd10, 6'd12, 6'd13, 6'd13,
		6'd13, 6'd13, 6'd14, 6'd16, 6'd17, 6'd27, 6'd28, 6'd28, 6'd22, 6'd29, 6'd32
	};

	// Fold ASCII upper case to lower case
	function automatic logic [7:0] fold_byte(input logic [7:0] b);
		logic [7:0] r;
		r = b;
		if (b >= 8'h41 && b <= 8'h5A) begin
			r = b + 8'h20;
		end
		return r;
	endfunction

	// Character of keyword k at position pos, valid only where pos < KW_LEN[k]
	function automatic logic [7:0] kw_char(input int k, input len_t pos);
		len_t idx;
		idx = KW_LEN[k] - pos - 6'd1;
		return KW_TEXT[k][{idx[4:0], 3'b000} +: 8];
	endfunction

endpackage

### rtl/http_header_name_classifier_unit.sv
// Top level of the HTTP header name classifier: state memory, update stage and result register.
//
//  channel | valid        | stall        | payload
//  --------+--------------+--------------+-----------------------------------
//  item    | item_valid   | item_stall   | name_byte, has_byte, is_last
//  result  | result_valid | result_stall | header_code
//
// One item per cycle while item_stall is low; a result is loaded into the result
// register as its last item leaves stage 1. Name state lives in a one-entry memory
// read when an item is taken; the write of the previous item is forwarded, so items
// run back to back. Reset clears the pipeline and marks the memory entry empty (reads
// as the reset state); no clearing pass is needed.
// item_stall rises only when an ending item waits for the result register.
module http_header_name_classifier_unit #(
	parameter int MAX_NAME_LEN = hhnc_pkg::MAX_NAME_LEN_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    item_valid,
	output logic                    item_stall,
	input  logic [7:0]              name_byte,
	input  logic                    has_byte,
	input  logic                    is_last,
	output logic                    result_valid,
	input  logic                    result_stall,
	output logic [hhnc_pkg::CODE_W-1:0] header_code
);

	localparam hhnc_pkg::len_t LEN_CAP = hhnc_pkg::len_t'(MAX_NAME_LEN);

	// Stage 1 registers and memory read path
	logic                  valid_s1;
	logic [7:0]            byte_s1;
	logic                  has_s1;
	logic                  last_s1;
	hhnc_pkg::name_state_t st_mem [1];
	hhnc_pkg::name_state_t rd_q;
	logic                  rd_ok_q;
	logic                  mem_ok_q;
	logic                  fwd_q;
	hhnc_pkg::name_state_t fwd_data_q;

	// Result register
	logic                  res_valid_q;
	hhnc_pkg::code_t       res_code_q;

	logic                  out_free;
	logic                  s1_go;
	logic                  take;
	logic                  wr_en;
	hhnc_pkg::name_state_t cur_st;
	hhnc_pkg::name_state_t upd_st;
	hhnc_pkg::name_state_t end_st;
	hhnc_pkg::name_state_t wr_data;
	hhnc_pkg::code_t       code_nx;
	logic [7:0]            folded;

	assign out_free   = !res_valid_q || !result_stall;
	assign s1_go      = !last_s1 || out_free;
	assign item_stall = valid_s1 && !s1_go;
	assign take       = item_valid && !item_stall;
	assign wr_en      = valid_s1 && s1_go && (has_s1 || last_s1);

	// Pick state: forwarded write, memory data, or reset value for an empty entry
	always_comb begin
		if (fwd_q) begin
			cur_st = fwd_data_q;
		end else if (rd_ok_q) begin
			cur_st = rd_q;
		end else begin
			cur_st = hhnc_pkg::STATE_RESET;
		end
	end

	// Compare the folded byte against every keyword at the current position; count the length up to the cap
	always_comb begin
		folded = hhnc_pkg::fold_byte(byte_s1);
		upd_st = cur_st;
		for (int k = 0; k < hhnc_pkg::KW_COUNT; k++) begin
			if (!(cur_st.name_len < hhnc_pkg::KW_LEN[k] &&
			      hhnc_pkg::kw_char(k, cur_st.name_len) == folded)) begin
				upd_st.match[k] = 1'b0;
			end
		end
		if (cur_st.name_len < LEN_CAP) begin
			upd_st.name_len = cur_st.name_len + 6'd1;
		end
	end

	// Classify at the end of a name; lowest code wins
	always_comb begin
		end_st  = has_s1 ? upd_st : cur_st;
		code_nx = '0;
		for (int k = hhnc_pkg::KW_COUNT - 1; k >= 0; k--) begin
			if (end_st.match[k] && end_st.name_len == hhnc_pkg::KW_LEN[k]) begin
				code_nx = hhnc_pkg::code_t'(k + 1);
			end
		end
		wr_data = last_s1 ? hhnc_pkg::STATE_RESET : upd_st;
	end

	// Write back state and read it for the next item
	always_ff @(posedge clk) begin
		if (wr_en) begin
			st_mem[0] <= wr_data;
		end
		if (take) begin
			rd_q <= st_mem[0];
		end
	end

	// Forwarding and memory-valid control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_ok_q <= 1'b0;
			rd_ok_q  <= 1'b0;
			fwd_q    <= 1'b0;
		end else begin
			if (wr_en) begin
				mem_ok_q <= 1'b1;
			end
			if (take) begin
				rd_ok_q <= mem_ok_q;
				fwd_q   <= wr_en;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && wr_en) begin
			fwd_data_q <= wr_data;
		end
	end

	// Stage 1 item register: advance on take, drop when done
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			byte_s1 <= name_byte;
			has_s1  <= has_byte;
			last_s1 <= is_last;
		end
	end

	// Result register: load on a finished name, hold while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (valid_s1 && last_s1 && out_free) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && last_s1 && out_free) begin
			res_code_q <= code_nx;
		end
	end

	assign result_valid = res_valid_q;
	assign header_code  = res_code_q;

	// Checks
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> !item_stall)
		else $error("input stalled with stage 1 empty");

	a_end_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && last_s1 && s1_go) |=> res_valid_q)
		else $error("ending item produced no result");

	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> (res_code_q <= hhnc_pkg::code_t'(hhnc_pkg::KW_COUNT)))
		else $error("header code out of range");

	a_len_capped: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (cur_st.name_len <= LEN_CAP))
		else $error("name length beyond cap");

endmodule

### tb/tb_top.sv
// Testbench for the HTTP header name classifier: directed table, random names, predicted codes.
module tb_top;

	localparam int NAME_CAP = 32;
	localparam int IDLE_LIMIT = 5000;
	localparam int RANDOM_ITEMS = 1300;
	localparam int MAX_REPORTS = 10;
	localparam int DIR_ROWS = 25;

	localparam hhnc_pkg::code_t CODE_UNKNOWN = 5'd0;
	localparam hhnc_pkg::code_t CODE_DATE = 5'd1;
	localparam hhnc_pkg::code_t CODE_ETAG = 5'd2;
	localparam hhnc_pkg::code_t CODE_VARY = 5'd3;

	// One directed item; known marks a code that is typed in rather than predicted
	typedef struct packed {
		logic [7:0]      nb;
		logic            has;
		logic            last;
		logic            known;
		hhnc_pkg::code_t code;
	} dir_row_t;

	logic            clk = 1'b0;
	logic            arst_n = 1'b1;
	logic            item_valid = 1'b0;
	logic            item_stall;
	logic [7:0]      name_byte = 8'h00;
	logic            has_byte = 1'b0;
	logic            is_last = 1'b0;
	logic            result_valid;
	logic            result_stall = 1'b0;
	hhnc_pkg::code_t header_code;

	// Sideband that travels with each item: a hand-written code for its result
	logic            known_en = 1'b0;
	hhnc_pkg::code_t known_code = CODE_UNKNOWN;

	int send_idle_pct = 25;
	int recv_idle_pct = 82;
	int items_sent = 0;
	int names_closed = 0;
	int results_checked = 0;
	int keyword_hits = 0;
	int long_names = 0;
	int fault_count = 0;
	int quiet_cycles = 0;

	// Header names in file order; code is index plus one
	string kw_names [hhnc_pkg::KW_COUNT] = '{
		"date", "etag", "vary", "allow", "server", "location", "connection",
		"set-cookie", "content-type", "accept-ranges", "cache-control",
		"content-range", "last-modified", "content-length", "content-encoding",
		"transfer-encoding", "access-control-allow-origin",
		"access-control-allow-methods", "access-control-allow-headers",
		"access-control-max-age", "access-control-expose-headers",
		"access-control-allow-credentials"
	};

	dir_row_t dir_rows [DIR_ROWS] = '{
		// neither byte nor end: nothing happens
		'{8'h5A, 1'b0, 1'b0, 1'b0, CODE_UNKNOWN},
		// empty name
		'{8'hFF, 1'b0, 1'b1, 1'b1, CODE_UNKNOWN},
		// mixed case, end on the last byte
		'{"D", 1'b1, 1'b0, 1'b0, CODE_UNKNOWN},
		'{"a", 1'b1, 1'b0, 1'b0, CODE_UNKNOWN},
		'{"T", 1'b1, 1'b0, 1'b0, CODE_UNKNOWN},
		'{"e", 1'b1, 1'b1, 1'b1, CODE_DATE},
		// end given by a bare terminator
		'{"v", 1'b1, 1'b0, 1'b0, CODE_UNKNOWN},
		'{"A", 1'b1, 1'b0, 1'b0, CODE_UNKNOWN},
		'{"R", 1'b1, 1'b0, 1'b0, CODE_UNKNOWN},
		'{"Y", 1'b1, 1'b0, 1'b0, CODE_UNKNOWN},
		'{8'h00, 1'b0, 1'b1, 1'b1, CODE_VARY},
		// extreme byte values as one-byte names
		'{8'hFF, 1'b1, 1'b1, 1'b1, CODE_UNKNOWN},
		'{8'h00, 1'b1, 1'b1, 1'b1, CODE_UNKNOWN},
		// all upper case
		'{"E", 1'b1, 1'b0, 1'b0, CODE_UNKNOWN},
		'{"T", 1'b1, 1'b0, 1'b0, CODE_UNKNOWN},
		'{"A", 1'b1, 1'b0, 1'b0, CODE_UNKNOWN},
		'{"G", 1'b1, 1'b1, 1'b1, CODE_ETAG},
		// prefix of a keyword
		'{"d", 1'b1, 1'b0, 1'b0, CODE_UNKNOWN},
		'{"a", 1'b1, 1'b0, 1'b0, CODE_UNKNOWN},
		'{"t", 1'b1, 1'b1, 1'b0, CODE_UNKNOWN},
		// keyword followed by one more byte
		'{"d", 1'b1, 1'b0, 1'b0, CODE_UNKNOWN},
		'{"a", 1'b1, 1'b0, 1'b0, CODE_UNKNOWN},
		'{"t", 1'b1, 1'b0, 1'b0, CODE_UNKNOWN},
		'{"e", 1'b1, 1'b0, 1'b0, CODE_UNKNOWN},
		'{"s", 1'b1, 1'b1, 1'b0, CODE_UNKNOWN}
	};

	hhnc_pkg::code_t pending_codes [$];

	// Classifier state as predicted
	hhnc_pkg::len_t   pred_len = '0;
	hhnc_pkg::match_t pred_match = '1;

	http_header_name_classifier_unit #(
		.MAX_NAME_LEN(NAME_CAP)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.name_byte(name_byte),
		.has_byte(has_byte),
		.is_last(is_last),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.header_code(header_code)
	);

	always #5 clk = ~clk;

	function automatic logic [7:0] to_lower(input logic [7:0] b);
		return (b >= 8'h41 && b <= 8'h5A) ? b + 8'h20 : b;
	endfunction

	// Drop every keyword whose character at this position differs
	function automatic void absorb_byte(input logic [7:0] b);
		logic [7:0] c;
		c = to_lower(b);
		for (int k = 0; k < hhnc_pkg::KW_COUNT; k++) begin
			if (!(pred_len < kw_names[k].len() && kw_names[k][pred_len] == c)) begin
				pred_match[k] = 1'b0;
			end
		end
		if (pred_len < NAME_CAP) begin
			pred_len = pred_len + 1'b1;
		end
	endfunction

	// Pick the first keyword still matching at full length, then start afresh
	function automatic hhnc_pkg::code_t close_name();
		hhnc_pkg::code_t c;
		c = CODE_UNKNOWN;
		for (int k = hhnc_pkg::KW_COUNT - 1; k >= 0; k--) begin
			if (pred_match[k] && kw_names[k].len() == pred_len) begin
				c = hhnc_pkg::code_t'(k + 1);
			end
		end
		pred_len = '0;
		pred_match = '1;
		return c;
	endfunction

	function automatic void note_fault(input string what, input hhnc_pkg::code_t want,
			input hhnc_pkg::code_t got);
		fault_count++;
		if (fault_count <= MAX_REPORTS) begin
			$display("mismatch: %s, expected %0d, got %0d at %0t", what, want, got, $time);
		end
	endfunction

	// Predict on each taken item, check each taken result
	always @(posedge clk) begin
		hhnc_pkg::code_t want;
		if (arst_n && item_valid && !item_stall) begin
			if (has_byte) begin
				absorb_byte(name_byte);
			end
			if (is_last) begin
				want = close_name();
				names_closed++;
				if (want != CODE_UNKNOWN) begin
					keyword_hits++;
				end
				pending_codes.push_back(known_en ? known_code : want);
			end
		end
		if (arst_n && result_valid && !result_stall) begin
			results_checked++;
			if (pending_codes.size() == 0) begin
				note_fault("result with none pending", CODE_UNKNOWN, header_code);
			end else begin
				want = pending_codes.pop_front();
				if (header_code !== want) begin
					note_fault("header_code", want, header_code);
				end
			end
		end
	end

	// Stall the result channel at random
	always @(posedge clk) begin
		result_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	// End the run when nothing moves for too long
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	// Offer one item, idling first at random, and hold it until taken
	task automatic send_item(input logic [7:0] b, input logic has, input logic last,
			input logic known, input hhnc_pkg::code_t code);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		name_byte <= b;
		has_byte <= has;
		is_last <= last;
		known_en <= known;
		known_code <= code;
		@(posedge clk);
		while (item_stall) begin
			@(posedge clk);
		end
		if (has || last) begin
			items_sent++;
		end
	endtask

	// Send a name byte by byte, with stray empty items mixed in
	task automatic send_name(input logic [7:0] chars [$], input bit bare_end);
		int n;
		n = chars.size();
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(19) == 0) begin
				send_item(8'($urandom), 1'b0, 1'b0, 1'b0, CODE_UNKNOWN);
			end
			send_item(chars[i], 1'b1, (i == n - 1) && !bare_end, 1'b0, CODE_UNKNOWN);
		end
		if (bare_end || n == 0) begin
			send_item(8'($urandom), 1'b0, 1'b1, 1'b0, CODE_UNKNOWN);
		end
	endtask

	// Mostly keywords in random case; some damaged, cut, lengthened or pure noise
	task automatic random_name();
		logic [7:0] chars [$];
		logic [7:0] c;
		string word;
		int pick;
		int n;
		pick = $urandom_range(99);
		word = kw_names[$urandom_range(hhnc_pkg::KW_COUNT - 1)];
		if (pick >= 88) begin
			n = ($urandom_range(7) == 0) ? $urandom_range(70, 33) : $urandom_range(8);
			repeat (n) begin
				chars.push_back(8'($urandom));
			end
		end else begin
			for (int i = 0; i < word.len(); i++) begin
				c = word[i];
				if (c >= "a" && c <= "z" && $urandom_range(1) == 1) begin
					c = c - 8'h20;
				end
				chars.push_back(c);
			end
			if (pick >= 60 && pick < 70) begin
				chars[$urandom_range(chars.size() - 1)] = 8'($urandom);
			end else if (pick >= 70 && pick < 75) begin
				void'(chars.pop_back());
			end else if (pick >= 75 && pick < 80) begin
				chars.push_back(8'($urandom));
			end else if (pick >= 80) begin
				repeat ($urandom_range(40, 1)) begin
					chars.push_back(word[$urandom_range(word.len() - 1)]);
				end
			end
		end
		if (chars.size() > NAME_CAP) begin
			long_names++;
		end
		send_name(chars, $urandom_range(3) == 0);
	endtask

	initial begin
		int base;
		int phase;
		arst_n <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed table
		foreach (dir_rows[i]) begin
			send_item(dir_rows[i].nb, dir_rows[i].has, dir_rows[i].last,
				dir_rows[i].known, dir_rows[i].code);
		end

		// Random names in three idling phases
		base = items_sent;
		while (items_sent < base + RANDOM_ITEMS) begin
			phase = (items_sent - base) * 3 / RANDOM_ITEMS;
			if (phase == 0) begin
				send_idle_pct = 25;
				recv_idle_pct = 82;
			end else if (phase == 1) begin
				send_idle_pct = 82;
				recv_idle_pct = 25;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			random_name();
		end
		item_valid <= 1'b0;

		// Drain outstanding results
		@(posedge clk);
		while (pending_codes.size() != 0) begin
			@(posedge clk);
		end
		repeat (8) @(posedge clk);
		while (pending_codes.size() != 0) begin
			note_fault("result never came", pending_codes.pop_front(), CODE_UNKNOWN);
		end

		$display("summary: %0d items over %0d names, %0d results checked", items_sent,
			names_closed, results_checked);
		$display("summary: %0d keyword hits, %0d names past the length cap, %0d faults",
			keyword_hits, long_names, fault_count);
		if (fault_count == 0) begin
			$display("tb_top: clean");
		end else begin
			$display("tb_top: errors");
		end
		$finish;
	end

endmodule
